[sv/vfc_pkg.sv]
// Shared types, codes and shade tables for the voxel face cull and AO shader.
// No dependencies; imported by every module of the block.
package vfc_pkg;

    typedef logic [1:0] kind_t;
    typedef logic [2:0] face_id_t;
    typedef logic [8:0] factor_t;
    typedef logic [5:0] face_mask_t;
    typedef logic [3:0][8:0] shade_set_t;

    localparam kind_t KIND_AIR   = 2'd0;
    localparam kind_t KIND_WATER = 2'd1;

    localparam face_id_t FACE_TOP    = 3'd0;
    localparam face_id_t FACE_BOTTOM = 3'd1;
    localparam face_id_t FACE_POS_X  = 3'd2;
    localparam face_id_t FACE_NEG_X  = 3'd3;
    localparam face_id_t FACE_POS_Z  = 3'd4;
    localparam face_id_t FACE_NEG_Z  = 3'd5;

    localparam int NUM_FACES = 6;

    localparam factor_t SIDE_SHADE = 9'd184;

    function automatic logic [1:0] ao_level(input logic e1, input logic e2, input logic c);
        logic [1:0] opaque_cnt;
        opaque_cnt = {1'b0, e1} + {1'b0, e2} + {1'b0, c};
        if (e1 && e2)
            return 2'd0;
        return 2'd3 - opaque_cnt;
    endfunction

    function automatic factor_t top_shade(input logic [1:0] lvl);
        case (lvl)
            2'd0:    return 9'd141;
            2'd1:    return 9'd179;
            2'd2:    return 9'd218;
            default: return 9'd256;
        endcase
    endfunction

    function automatic factor_t bottom_shade(input logic [1:0] lvl);
        case (lvl)
            2'd0:    return 9'd84;
            2'd1:    return 9'd108;
            2'd2:    return 9'd131;
            default: return 9'd154;
        endcase
    endfunction

endpackage

[sv/vfc_ao.sv]
// Corner ambient occlusion: four vertex shade factors for a top or bottom face.
// Depends on vfc_pkg.
module vfc_ao
    import vfc_pkg::*;
(
    input  logic [8:0] layer,
    input  logic       is_top,
    output shade_set_t factors
);

    logic       s1, s2, s3, s4;
    logic       c1, c2, c3, c4;
    logic [1:0] a0, a1, a2, a3;

    assign s1 = layer[1];
    assign s2 = layer[3];
    assign s3 = layer[7];
    assign s4 = layer[5];
    assign c1 = layer[0];
    assign c2 = layer[6];
    assign c3 = layer[8];
    assign c4 = layer[2];

    always_comb
    begin
        a0 = ao_level(s1, s2, c1);
        a2 = ao_level(s3, s4, c3);
        if (is_top)
        begin
            a1 = ao_level(s1, s4, c4);
            a3 = ao_level(s3, s2, c2);
            factors[0] = top_shade(a0);
            factors[1] = top_shade(a1);
            factors[2] = top_shade(a2);
            factors[3] = top_shade(a3);
        end
        else
        begin
            a1 = ao_level(s3, s2, c2);
            a3 = ao_level(s1, s4, c4);
            factors[0] = bottom_shade(a0);
            factors[1] = bottom_shade(a1);
            factors[2] = bottom_shade(a2);
            factors[3] = bottom_shade(a3);
        end
    end

endmodule

[sv/vfc_shade.sv]
// Scales the RGB channels of one RGBA colour by a 1/256 shade factor, with saturation.
// Depends on vfc_pkg.
module vfc_shade
    import vfc_pkg::*;
(
    input  logic [31:0] base,
    input  factor_t     factor,
    output logic [31:0] color
);

    always_comb
    begin
        logic [16:0] prod;
        color[7:0] = base[7:0];
        for (int ch = 1; ch < 4; ch++)
        begin
            prod = {9'd0, base[ch*8 +: 8]} * {8'd0, factor};
            if (prod[16])
                color[ch*8 +: 8] = 8'hFF;
            else
                color[ch*8 +: 8] = prod[15:8];
        end
    end

endmodule

[sv/voxel_face_cull_ao_shader.sv]
// Top level of the voxel face cull and AO shader: voxel register, face walk, result register.
// Depends on vfc_pkg, vfc_ao and vfc_shade.
//
// Usage:
//   A voxel word is taken at a rising edge where start is high and busy is low.
//   At that edge the visible faces are worked out and held in a face mask.
//   Each following cycle the lowest remaining face is shaded and registered;
//   it shows on the result ports with done high for exactly one cycle. The
//   first face is shaded from the loaded face mask, then registered onto the
//   result ports, where the receiver takes it. Faces come in the
//   order top, bottom, +x, -x, +z, -z, and last_face marks the final one.
//   busy is high while more than one face is still to be emitted, so the next
//   voxel is taken at the edge that registers the last face of the current one.
//   The face walk, one face per cycle through the shading unit, sets the rate.
//   Air voxels and voxels with no visible face give no result.
//   Reset clears the face mask and done; nothing is pending afterwards.
//   The receiver cannot stall: every result must be taken as it appears.
module voxel_face_cull_ao_shader
    import vfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  center_kind,
    input  logic [8:0]  above_opaque,
    input  logic [8:0]  below_opaque,
    input  logic [3:0]  side_opaque,
    input  logic [3:0]  side_water,
    input  logic        above_is_air,
    input  logic [31:0] top_color,
    input  logic [31:0] bottom_color,
    input  logic [31:0] side_color,
    input  logic signed [20:0] pos_x,
    input  logic [7:0]  pos_y,
    input  logic signed [20:0] pos_z,
    output logic        done,
    output logic [2:0]  face_id,
    output logic        water_face,
    output logic signed [20:0] quad_x,
    output logic [7:0]  quad_y,
    output logic signed [20:0] quad_z,
    output logic [31:0] vertex_color0,
    output logic [31:0] vertex_color1,
    output logic [31:0] vertex_color2,
    output logic [31:0] vertex_color3,
    output logic        last_face
);

    face_mask_t          mask_reg, mask_next, load_mask, remain_mask;
    logic [8:0]          above_reg, below_reg;
    logic [31:0]         top_color_reg, bottom_color_reg, side_color_reg;
    logic                water_reg;
    logic signed [20:0]  pos_x_reg, pos_z_reg;
    logic [7:0]          pos_y_reg;

    logic                accept;
    logic                load_water;
    face_id_t            cur_face;
    logic                is_top;
    logic [8:0]          ao_layer;
    shade_set_t          ao_factors;
    shade_set_t          sel_factors;
    logic [31:0]         sel_base;
    logic [3:0][31:0]    shaded;

    logic                done_reg;
    face_id_t            face_id_reg;
    logic                water_face_reg;
    logic signed [20:0]  quad_x_reg, quad_z_reg;
    logic [7:0]          quad_y_reg;
    logic [3:0][31:0]    vcolor_reg;
    logic                last_face_reg;

    assign busy   = |(mask_reg & (mask_reg - 6'd1));
    assign accept = start && !busy;

    // visible faces of the incoming voxel
    always_comb
    begin
        load_water = (center_kind == KIND_WATER);
        load_mask  = '0;
        if (center_kind != KIND_AIR)
        begin
            load_mask[FACE_TOP]    = load_water ? above_is_air : !above_opaque[4];
            load_mask[FACE_BOTTOM] = !load_water && !below_opaque[4];
            for (int b = 0; b < 4; b++)
                load_mask[2 + b] = !(side_opaque[b] || (load_water && side_water[b]));
        end
    end

    // pick the lowest remaining face
    always_comb
    begin
        cur_face = FACE_TOP;
        for (int f = NUM_FACES - 1; f >= 0; f--)
        begin
            if (mask_reg[f])
                cur_face = face_id_t'(f);
        end
        remain_mask = mask_reg & ~(face_mask_t'(1) << cur_face);
    end

    assign mask_next = accept ? load_mask : remain_mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= '0;
        else
            mask_reg <= mask_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            above_reg        <= above_opaque;
            below_reg        <= below_opaque;
            top_color_reg    <= top_color;
            bottom_color_reg <= bottom_color;
            side_color_reg   <= side_color;
            water_reg        <= load_water;
            pos_x_reg        <= pos_x;
            pos_y_reg        <= pos_y;
            pos_z_reg        <= pos_z;
        end
    end

    assign is_top   = (cur_face == FACE_TOP);
    assign ao_layer = is_top ? above_reg : below_reg;

    vfc_ao u_ao (
        .layer   (ao_layer),
        .is_top  (is_top),
        .factors (ao_factors)
    );

    always_comb
    begin
        case (cur_face)
            FACE_TOP:
            begin
                sel_factors = ao_factors;
                sel_base    = top_color_reg;
            end
            FACE_BOTTOM:
            begin
                sel_factors = ao_factors;
                sel_base    = bottom_color_reg;
            end
            default:
            begin
                sel_factors = {4{SIDE_SHADE}};
                sel_base    = side_color_reg;
            end
        endcase
    end

    for (genvar v = 0; v < 4; v++)
    begin : g_vertex
        vfc_shade u_shade (
            .base   (sel_base),
            .factor (sel_factors[v]),
            .color  (shaded[v])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= |mask_reg;
    end

    always_ff @(posedge clk)
    begin
        if (|mask_reg)
        begin
            face_id_reg    <= cur_face;
            water_face_reg <= water_reg;
            quad_x_reg     <= pos_x_reg;
            quad_y_reg     <= pos_y_reg;
            quad_z_reg     <= pos_z_reg;
            vcolor_reg     <= shaded;
            last_face_reg  <= (remain_mask == '0);
        end
    end

    assign done          = done_reg;
    assign face_id       = face_id_reg;
    assign water_face    = water_face_reg;
    assign quad_x        = quad_x_reg;
    assign quad_y        = quad_y_reg;
    assign quad_z        = quad_z_reg;
    assign vertex_color0 = vcolor_reg[0];
    assign vertex_color1 = vcolor_reg[1];
    assign vertex_color2 = vcolor_reg[2];
    assign vertex_color3 = vcolor_reg[3];
    assign last_face     = last_face_reg;

endmodule

[sv/vfc_checker.sv]
// Port-level checks for the voxel face cull and AO shader, bound to the top level.
// Depends on vfc_pkg and voxel_face_cull_ao_shader.
module vfc_checker
    import vfc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [2:0] face_id,
    input logic       water_face,
    input logic       last_face
);

    // a busy cycle always emits a face that is not the last one
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !last_face)
        else $error("busy without a following non-final face");

    // faces of one voxel come back to back in rising order
    assert property (@(posedge clk) disable iff (!rst_n)
        done && !last_face |=> done && (face_id > $past(face_id)))
        else $error("face sequence broken or out of order");

    // a new word is taken only once the previous voxel is finishing
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> !done || last_face)
        else $error("word accepted while faces remained");

    // water never draws a bottom face
    assert property (@(posedge clk) disable iff (!rst_n)
        done && water_face |-> face_id != FACE_BOTTOM)
        else $error("water bottom face emitted");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> face_id <= FACE_NEG_Z)
        else $error("face id out of range");

endmodule

bind voxel_face_cull_ao_shader vfc_checker u_vfc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .face_id    (face_id),
    .water_face (water_face),
    .last_face  (last_face)
);

[dv/voxel_face_cull_ao_shader_test.sv]
// Self-checking test of voxel_face_cull_ao_shader: a directed table, then random voxels,
// with every quad word checked against a face cull and corner AO predictor.
// Depends on vfc_pkg and the voxel_face_cull_ao_shader RTL.
module voxel_face_cull_ao_shader_test
    import vfc_pkg::*;
();

    localparam kind_t KIND_SOLID     = 2'd2;
    localparam kind_t KIND_SOLID_ALT = 2'd3;

    localparam int unsigned TOP_FACTOR[4]    = '{141, 179, 218, 256};
    localparam int unsigned BOTTOM_FACTOR[4] = '{84, 108, 131, 154};
    localparam int unsigned FLAT_FACTOR      = 184;

    localparam int DIR_ROWS        = 19;
    localparam int RANDOM_ITEMS    = 91;
    localparam int SETTLE_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT  = 2000;

    typedef struct {
        kind_t              kind;
        logic [8:0]         above;
        logic [8:0]         below;
        logic [3:0]         sop;
        logic [3:0]         swt;
        logic               air_up;
        logic [31:0]        tc;
        logic [31:0]        bc;
        logic [31:0]        sc;
        logic signed [20:0] x;
        logic [7:0]         y;
        logic signed [20:0] z;
        bit                 quiet;
    } voxel_t;

    typedef struct {
        face_id_t           face;
        logic               water;
        logic signed [20:0] x;
        logic [7:0]         y;
        logic signed [20:0] z;
        logic [3:0][31:0]   col;
        logic               last;
    } quad_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         center_kind;
    logic [8:0]         above_opaque;
    logic [8:0]         below_opaque;
    logic [3:0]         side_opaque;
    logic [3:0]         side_water;
    logic               above_is_air;
    logic [31:0]        top_color;
    logic [31:0]        bottom_color;
    logic [31:0]        side_color;
    logic signed [20:0] pos_x;
    logic [7:0]         pos_y;
    logic signed [20:0] pos_z;
    logic               done;
    logic [2:0]         face_id;
    logic               water_face;
    logic signed [20:0] quad_x;
    logic [7:0]         quad_y;
    logic signed [20:0] quad_z;
    logic [31:0]        vertex_color0;
    logic [31:0]        vertex_color1;
    logic [31:0]        vertex_color2;
    logic [31:0]        vertex_color3;
    logic               last_face;

    quad_t  quads_due[$];
    quad_t  quad_head;
    voxel_t dir_rows[DIR_ROWS];
    int     mismatches;
    int     idle_cycles;

    voxel_face_cull_ao_shader dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .center_kind  (center_kind),
        .above_opaque (above_opaque),
        .below_opaque (below_opaque),
        .side_opaque  (side_opaque),
        .side_water   (side_water),
        .above_is_air (above_is_air),
        .top_color    (top_color),
        .bottom_color (bottom_color),
        .side_color   (side_color),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .done         (done),
        .face_id      (face_id),
        .water_face   (water_face),
        .quad_x       (quad_x),
        .quad_y       (quad_y),
        .quad_z       (quad_z),
        .vertex_color0(vertex_color0),
        .vertex_color1(vertex_color1),
        .vertex_color2(vertex_color2),
        .vertex_color3(vertex_color3),
        .last_face    (last_face)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] shade_rgba(input logic [31:0] base, input int unsigned f);
        logic [31:0] rgba;
        int unsigned chan;
        rgba = {24'd0, base[7:0]};
        for (int sh = 8; sh <= 24; sh += 8)
        begin
            chan = ((base >> sh) & 32'hFF) * f >> 8;
            if (chan > 255)
                chan = 255;
            rgba = rgba | (chan << sh);
        end
        return rgba;
    endfunction

    function automatic int unsigned corner_level(input logic e1, input logic e2, input logic c);
        if (e1 && e2)
            return 0;
        return 3 - (int'(e1) + int'(e2) + int'(c));
    endfunction

    function automatic logic [3:0][31:0] cap_colours(input logic [8:0] layer,
                                                     input logic [31:0] base,
                                                     input bit is_top);
        logic [3:0][31:0] col;
        int unsigned      lvl[4];
        lvl[0] = corner_level(layer[1], layer[3], layer[0]);
        lvl[2] = corner_level(layer[7], layer[5], layer[8]);
        if (is_top)
        begin
            lvl[1] = corner_level(layer[1], layer[5], layer[2]);
            lvl[3] = corner_level(layer[7], layer[3], layer[6]);
        end
        else
        begin
            lvl[1] = corner_level(layer[7], layer[3], layer[6]);
            lvl[3] = corner_level(layer[1], layer[5], layer[2]);
        end
        for (int v = 0; v < 4; v++)
            col[v] = shade_rgba(base, is_top ? TOP_FACTOR[lvl[v]] : BOTTOM_FACTOR[lvl[v]]);
        return col;
    endfunction

    function automatic int predict_faces(input voxel_t v);
        quad_t faces[NUM_FACES];
        int    n;
        bit    water;
        bit    draw;
        water = (v.kind == KIND_WATER);
        n = 0;
        if (v.kind == KIND_AIR)
            return 0;
        for (int f = 0; f < NUM_FACES; f++)
        begin
            faces[n].face  = face_id_t'(f);
            faces[n].water = water;
            faces[n].x     = v.x;
            faces[n].y     = v.y;
            faces[n].z     = v.z;
            faces[n].last  = 1'b0;
            if (f == FACE_TOP)
            begin
                draw = water ? v.air_up : !v.above[4];
                faces[n].col = cap_colours(v.above, v.tc, 1'b1);
            end
            else if (f == FACE_BOTTOM)
            begin
                draw = !water && !v.below[4];
                faces[n].col = cap_colours(v.below, v.bc, 1'b0);
            end
            else
            begin
                draw = !(v.sop[f - FACE_POS_X] || (water && v.swt[f - FACE_POS_X]));
                faces[n].col = {4{shade_rgba(v.sc, FLAT_FACTOR)}};
            end
            if (draw)
                n++;
        end
        if (n > 0)
            faces[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++)
            quads_due = {quads_due, faces[i]};
        return n;
    endfunction

    function automatic logic [8:0] layer_bits();
        case ($urandom_range(3))
            0:       return 9'($urandom & $urandom);
            1:       return 9'($urandom | $urandom);
            2:       return 9'($urandom_range(1) ? 9'h010 : 9'h000) | (9'($urandom) & 9'h1EF);
            default: return 9'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] random_colour();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [20:0] random_coord();
        case ($urandom_range(7))
            0:       return 21'sh100000;
            1:       return 21'sh0FFFFF;
            default: return 21'($urandom);
        endcase
    endfunction

    function automatic voxel_t random_voxel();
        voxel_t      v;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8)
            v.kind = KIND_AIR;
        else if (pick < 40)
            v.kind = KIND_WATER;
        else if (pick < 85)
            v.kind = KIND_SOLID;
        else
            v.kind = KIND_SOLID_ALT;
        v.above  = layer_bits();
        v.below  = layer_bits();
        v.sop    = $urandom_range(1) ? 4'($urandom & $urandom) : 4'($urandom);
        v.swt    = 4'($urandom);
        v.air_up = 1'($urandom);
        v.tc     = random_colour();
        v.bc     = random_colour();
        v.sc     = random_colour();
        v.x      = random_coord();
        v.y      = 8'($urandom);
        v.z      = random_coord();
        v.quiet  = 1'b0;
        return v;
    endfunction

    task automatic drive_fields(input voxel_t v);
        center_kind  = v.kind;
        above_opaque = v.above;
        below_opaque = v.below;
        side_opaque  = v.sop;
        side_water   = v.swt;
        above_is_air = v.air_up;
        top_color    = v.tc;
        bottom_color = v.bc;
        side_color   = v.sc;
        pos_x        = v.x;
        pos_y        = v.y;
        pos_z        = v.z;
    endtask

    // Called at a falling edge; returns at the falling edge after the gap.
    task automatic send_voxel(input voxel_t v, input int unsigned idle_pct);
        drive_fields(v);
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        if (!v.quiet)
            void'(predict_faces(v));
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            drive_fields(random_voxel());
            @(negedge clk);
        end
    endtask

    task automatic drain_quads();
        while (quads_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (quads_due.size() == 0)
            begin
                $display("%0t: unexpected quad word, expected none, got face %0d",
                         $time, face_id);
                mismatches++;
            end
            else
            begin
                quad_head = quads_due.pop_front();
                check_field("face_id",       32'(quad_head.face),  32'(face_id));
                check_field("water_face",    32'(quad_head.water), 32'(water_face));
                check_field("quad_x",        32'(quad_head.x),     32'(quad_x));
                check_field("quad_y",        32'(quad_head.y),     32'(quad_y));
                check_field("quad_z",        32'(quad_head.z),     32'(quad_z));
                check_field("vertex_color0", quad_head.col[0],     vertex_color0);
                check_field("vertex_color1", quad_head.col[1],     vertex_color1);
                check_field("vertex_color2", quad_head.col[2],     vertex_color2);
                check_field("vertex_color3", quad_head.col[3],     vertex_color3);
                check_field("last_face",     32'(quad_head.last),  32'(last_face));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int unsigned idle_pct;
        int          item_no;
        voxel_t      v;

        mismatches   = 0;
        idle_cycles  = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        v            = '{KIND_AIR, 9'h0, 9'h0, 4'h0, 4'h0, 1'b0, 32'h0, 32'h0, 32'h0,
                         21'sh0, 8'h0, 21'sh0, 1'b0};
        drive_fields(v);

        // Rows marked quiet expect no quad word at all.
        dir_rows[0]  = '{KIND_AIR, 9'h1FF, 9'h1FF, 4'hF, 4'hF, 1'b1, 32'hFFFFFFFF,
                         32'hFFFFFFFF, 32'hFFFFFFFF, 21'sh0FFFFF, 8'hFF, 21'sh0FFFFF, 1'b1};
        dir_rows[1]  = '{KIND_AIR, 9'h000, 9'h000, 4'h0, 4'h0, 1'b0, 32'h0, 32'h0, 32'h0,
                         21'sh000000, 8'h00, 21'sh000000, 1'b1};
        dir_rows[2]  = '{KIND_SOLID, 9'h1FF, 9'h1FF, 4'hF, 4'h0, 1'b1, 32'h12345678,
                         32'h9ABCDEF0, 32'h0F0F0F0F, 21'sh000001, 8'd1, 21'sh1FFFFF, 1'b1};
        dir_rows[3]  = '{KIND_WATER, 9'h000, 9'h000, 4'b0101, 4'b1010, 1'b0, 32'hFFFFFFFF,
                         32'hFFFFFFFF, 32'hFFFFFFFF, 21'sh100000, 8'h80, 21'sh0FFFFF, 1'b1};
        dir_rows[4]  = '{KIND_SOLID, 9'h000, 9'h000, 4'h0, 4'h0, 1'b0, 32'hFFFFFFFF,
                         32'hFFFFFFFF, 32'hFFFFFFFF, 21'sh0FFFFF, 8'hFF, 21'sh0FFFFF, 1'b0};
        dir_rows[5]  = '{KIND_SOLID_ALT, 9'h000, 9'h000, 4'h0, 4'h0, 1'b1, 32'h0, 32'h0,
                         32'h0, 21'sh100000, 8'h00, 21'sh100000, 1'b0};
        dir_rows[6]  = '{KIND_WATER, 9'h1FF, 9'h000, 4'hF, 4'h0, 1'b1, 32'h80FF40C0,
                         32'hFFFFFFFF, 32'h10203040, 21'sh012345, 8'd64, 21'sh154321, 1'b0};
        dir_rows[7]  = '{KIND_WATER, 9'h000, 9'h000, 4'h0, 4'h0, 1'b0, 32'hFFFFFFFF,
                         32'hFFFFFFFF, 32'hC0FFEE55, 21'sh1FFFFF, 8'd63, 21'sh000000, 1'b0};
        dir_rows[8]  = '{KIND_WATER, 9'h0AA, 9'h1FF, 4'b0100, 4'b0011, 1'b1, 32'hFF8001FF,
                         32'h01020304, 32'hFEDCBA98, 21'sh0AAAAA, 8'hAA, 21'sh155555, 1'b0};
        dir_rows[9]  = '{KIND_SOLID, 9'h010, 9'h1EF, 4'h0, 4'h0, 1'b0, 32'h11111111,
                         32'hFFFFFF00, 32'h7F7F7F7F, 21'sh155555, 8'h55, 21'sh0AAAAA, 1'b0};
        dir_rows[10] = '{KIND_SOLID, 9'h1EF, 9'h010, 4'hF, 4'hF, 1'b1, 32'hFFFFFF00,
                         32'h22222222, 32'h80808080, 21'sh000000, 8'h00, 21'sh000001, 1'b0};
        dir_rows[11] = '{KIND_SOLID, 9'h145, 9'h145, 4'hF, 4'h0, 1'b0, 32'hC8C8C8C8,
                         32'hC8C8C8C8, 32'h0, 21'sh000100, 8'd200, 21'sh1FFF00, 1'b0};
        dir_rows[12] = '{KIND_SOLID, 9'h0AA, 9'h0AA, 4'hF, 4'h0, 1'b0, 32'hFFFFFFFF,
                         32'hFFFFFFFF, 32'h0, 21'sh0F0F0F, 8'h0F, 21'sh10F0F0, 1'b0};
        dir_rows[13] = '{KIND_SOLID, 9'h002, 9'h008, 4'hF, 4'h0, 1'b0, 32'h80402010,
                         32'hF0E0D0C0, 32'h0, 21'sh000FFF, 8'hF0, 21'sh1FF000, 1'b0};
        dir_rows[14] = '{KIND_SOLID_ALT, 9'h021, 9'h180, 4'hF, 4'h0, 1'b0, 32'hA5A5A5A5,
                         32'h5A5A5A5A, 32'h0, 21'sh07FFFF, 8'h7F, 21'sh180000, 1'b0};
        dir_rows[15] = '{KIND_SOLID, 9'h010, 9'h010, 4'b1110, 4'h0, 1'b1, 32'h0, 32'h0,
                         32'hFFFFFFFF, 21'sh000010, 8'd16, 21'sh000020, 1'b0};
        dir_rows[16] = '{KIND_SOLID, 9'h1EF, 9'h1EF, 4'h0, 4'hF, 1'b0, 32'h3C3C3C3C,
                         32'hC3C3C3C3, 32'h01FF7F80, 21'sh100001, 8'd128, 21'sh0FFFFE, 1'b0};
        dir_rows[17] = '{KIND_SOLID, 9'h010, 9'h010, 4'b0111, 4'b1000, 1'b0, 32'h0, 32'h0,
                         32'h00FF00FF, 21'sh123456, 8'd7, 21'sh065432, 1'b0};
        dir_rows[18] = '{KIND_WATER, 9'h145, 9'h000, 4'h0, 4'h0, 1'b1, 32'hFF00FF80,
                         32'h0, 32'hFFFFFFFF, 21'sh0FFFFF, 8'hFF, 21'sh100000, 1'b0};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
            send_voxel(dir_rows[r], (r % 4 == 3) ? 50 : 0);

        start = 1'b0;
        drain_quads();

        item_no = 0;
        while (item_no < RANDOM_ITEMS)
        begin
            case ((item_no / 25) % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 61;
                default: idle_pct = 17;
            endcase
            if (item_no == 60)
            begin
                start = 1'b0;
                drain_quads();
            end
            send_voxel(random_voxel(), idle_pct);
            item_no++;
        end

        start = 1'b0;
        drain_quads();

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
